// ----- hdl/rbdc_pkg.sv -----
// ----------------------------------------------------------------------------
// rbdc_pkg
// Shared types and constants for the relay bank dwell controller.
// ----------------------------------------------------------------------------
package rbdc_pkg;

  localparam int CHANNELS         = 14;
  localparam int TICKS_PER_SECOND = 1000;

  localparam int FIELD_W  = 14;
  localparam int TIME_W   = 32;
  localparam int HOLD_S_W = 16;
  localparam int LIVE_CH  = (CHANNELS < FIELD_W) ? CHANNELS : FIELD_W;

  // hold time kept in ticks: seconds times ticks per second
  localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
  localparam int HOLD_W = HOLD_S_W + TPS_W;
  localparam int CMP_W  = (HOLD_W > TIME_W) ? HOLD_W : TIME_W;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = HOLD_S_W;

  localparam logic [CFG_ADDR_W-1:0] REG_AUTO_ENABLE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_HOLD    = 1'd1;

  typedef struct packed {
    logic [FIELD_W-1:0] manual_request;
    logic [FIELD_W-1:0] auto_request;
    logic [TIME_W-1:0]  now_ticks;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] turn_on_mask;
    logic [FIELD_W-1:0] turn_off_mask;
    logic               notify;
    logic [FIELD_W-1:0] active_mask;
  } out_item_t;

  typedef struct packed {
    logic              auto_en;
    logic [HOLD_W-1:0] hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic active;
    logic changed;
    logic note;
  } chan_res_t;

endpackage

// ----- hdl/rbdc_cfg.sv -----
// ----------------------------------------------------------------------------
// rbdc_cfg
// Configuration registers; the hold time is stored already scaled to ticks.
// ----------------------------------------------------------------------------
module rbdc_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rbdc_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [rbdc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output rbdc_pkg::cfg_t                   cfg_o
);

  logic                          auto_en_q, auto_en_d;
  logic [rbdc_pkg::HOLD_W-1:0]   hold_ticks_q, hold_ticks_d;

  always_comb begin
    auto_en_d    = auto_en_q;
    hold_ticks_d = hold_ticks_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        rbdc_pkg::REG_AUTO_ENABLE: auto_en_d = cfg_wdata_i[0];
        rbdc_pkg::REG_MIN_HOLD: begin
          hold_ticks_d = rbdc_pkg::HOLD_W'(cfg_wdata_i)
                       * rbdc_pkg::HOLD_W'(rbdc_pkg::TICKS_PER_SECOND);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_en_q    <= 1'b0;
      hold_ticks_q <= '0;
    end else begin
      auto_en_q    <= auto_en_d;
      hold_ticks_q <= hold_ticks_d;
    end
  end

  assign cfg_o.auto_en    = auto_en_q;
  assign cfg_o.hold_ticks = hold_ticks_q;

endmodule

// ----- hdl/rbdc_chan.sv -----
// ----------------------------------------------------------------------------
// rbdc_chan
// One relay channel: active state, last switch time and switch decision.
// ----------------------------------------------------------------------------
module rbdc_chan (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         man_i,
  input  logic                         aut_i,
  input  logic [rbdc_pkg::TIME_W-1:0]  now_i,
  input  rbdc_pkg::cfg_t               cfg_i,
  output rbdc_pkg::chan_res_t          res_o
);

  logic                         active_q, active_d;
  logic                         ever_q, ever_d;
  logic [rbdc_pkg::TIME_W-1:0]  stamp_q, stamp_d;

  logic                         man_diff, aut_diff, hold_ok, auto_sw, sw;
  logic [rbdc_pkg::TIME_W-1:0]  elapsed;

  always_comb begin
    elapsed  = now_i - stamp_q;
    man_diff = man_i != active_q;
    aut_diff = cfg_i.auto_en && (aut_i != active_q);
    // floor(elapsed / tps) >= hold  <=>  elapsed >= hold * tps
    hold_ok  = !ever_q || (rbdc_pkg::CMP_W'(elapsed) >= rbdc_pkg::CMP_W'(cfg_i.hold_ticks));
    auto_sw  = !man_diff && aut_diff && hold_ok;
    sw       = man_diff || auto_sw;

    res_o.active  = active_q ^ sw;
    res_o.changed = sw;
    res_o.note    = auto_sw;

    active_d = active_q;
    ever_d   = ever_q;
    stamp_d  = stamp_q;
    if (en_i && sw) begin
      active_d = ~active_q;
      ever_d   = 1'b1;
      stamp_d  = now_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      ever_q   <= 1'b0;
      stamp_q  <= '0;
    end else begin
      active_q <= active_d;
      ever_q   <= ever_d;
      stamp_q  <= stamp_d;
    end
  end

endmodule

// ----- hdl/relay_bank_dwell_controller_top.sv -----
// ----------------------------------------------------------------------------
// relay_bank_dwell_controller_top
// Relay bank controller with manual override and dwell-limited auto switching.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------
//   input    | in_valid_i/in_ready_o  | in_item_i  (in_item_t)
//   output   | out_valid_o/out_ready_i| out_item_o (out_item_t)
//   config   | cfg_we_i               | cfg_addr_i, cfg_wdata_i
//
// One item per cycle sustained while out_ready_i is high. Items pass through the
// input register, then all channels decide in parallel into the result register.
// Reset clears all channel state and configuration.
// A stalled result holds the compute stage; the input register still takes
// one item while the result waits.
// ----------------------------------------------------------------------------
module relay_bank_dwell_controller_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  rbdc_pkg::in_item_t               in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output rbdc_pkg::out_item_t              out_item_o,
  input  logic                             cfg_we_i,
  input  logic [rbdc_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [rbdc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  rbdc_pkg::cfg_t       cfg;
  rbdc_pkg::in_item_t   in_q;
  rbdc_pkg::out_item_t  out_q, out_d;
  logic                 in_valid_q, in_valid_d;
  logic                 out_valid_q, out_valid_d;
  logic                 advance;

  logic [rbdc_pkg::FIELD_W-1:0] act_new, changed, note;

  rbdc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  for (genvar i = 0; i < rbdc_pkg::FIELD_W; i++) begin : g_ch
    if (i < rbdc_pkg::LIVE_CH) begin : g_live
      rbdc_pkg::chan_res_t res;
      rbdc_chan u_chan (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (advance),
        .man_i  (in_q.manual_request[i]),
        .aut_i  (in_q.auto_request[i]),
        .now_i  (in_q.now_ticks),
        .cfg_i  (cfg),
        .res_o  (res)
      );
      assign act_new[i] = res.active;
      assign changed[i] = res.changed;
      assign note[i]    = res.note;
    end else begin : g_dead
      assign act_new[i] = 1'b0;
      assign changed[i] = 1'b0;
      assign note[i]    = 1'b0;
    end
  end

  always_comb begin
    out_d.turn_on_mask  = changed & act_new;
    out_d.turn_off_mask = changed & ~act_new;
    out_d.notify        = |note;
    out_d.active_mask   = act_new;

    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- hdl/rbdc_checker.sv -----
// ----------------------------------------------------------------------------
// rbdc_checker
// Port-level checks for the relay bank dwell controller, bound to the top.
// ----------------------------------------------------------------------------
module rbdc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input rbdc_pkg::in_item_t               in_item_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input rbdc_pkg::out_item_t              out_item_o
);

  // a waiting update stays put
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_item_i))
    else $error("update changed while waiting");

  // a waiting result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  a_on_off_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.turn_on_mask & out_item_o.turn_off_mask) == '0)
    else $error("channel both switched on and off");

  a_masks_match_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_item_o.turn_on_mask & ~out_item_o.active_mask) == '0)
                 && ((out_item_o.turn_off_mask & out_item_o.active_mask) == '0))
    else $error("switch masks disagree with active mask");

  a_notify_needs_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.notify
      |-> (out_item_o.turn_on_mask | out_item_o.turn_off_mask) != '0)
    else $error("notify without any switch");

endmodule

bind relay_bank_dwell_controller_top rbdc_checker u_rbdc_checker (.*);
